@@ hw/rtl/dpms_pkg.sv @@
// Shared types, constants and codes of the damped puck motion step block.
// Used by every module under hw/rtl; depends on nothing else.

package dpms_pkg;

    // Field and datapath widths
    localparam int POS_W   = 20;            // signed Q11.8 position / velocity
    localparam int Q16_W   = 16;            // mass, push strength, damping
    localparam int SUB_W   = 45;            // shared subtract/compare unit
    localparam int MUL_A_W = 28;            // shared multiplier, wide operand
    localparam int MUL_B_W = 20;            // shared multiplier, narrow operand
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 44;            // divisor: root * mass
    localparam int NQ_W    = 28;            // dividend bits out, quotient bits in
    localparam int ROOT_W  = 28;            // square root of the push length
    localparam int SQREM_W = 29;            // square root partial remainder
    localparam int SQ_W    = 40;            // push_x^2 + push_y^2
    localparam int RAD_W   = 56;            // radicand: squared length << 16
    localparam int CNT_W   = 5;

    // Iteration counts of the shared subtract unit
    localparam logic [CNT_W-1:0] IMP_ITER  = CNT_W'(28);
    localparam logic [CNT_W-1:0] SQRT_ITER = CNT_W'(28);
    localparam logic [CNT_W-1:0] PUSH_ITER = CNT_W'(25);

    // Configuration register map (index = paddr[4:2])
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_MASS          = 3'd0;
    localparam logic [2:0] REG_PUSH_STRENGTH = 3'd1;
    localparam logic [2:0] REG_DAMPING       = 3'd2;
    localparam logic [2:0] REG_BORDER_LEFT   = 3'd3;
    localparam logic [2:0] REG_BORDER_RIGHT  = 3'd4;
    localparam logic [2:0] REG_BORDER_TOP    = 3'd5;
    localparam logic [2:0] REG_BORDER_BOTTOM = 3'd6;

    // Register reset values
    localparam logic [Q16_W-1:0] MASS_RST     = 16'd15360;   // 60.0
    localparam logic [Q16_W-1:0] PUSH_RST     = 16'd768;     // 3.0
    localparam logic [Q16_W-1:0] DAMP_RST     = 16'd58982;   // ~0.90
    localparam logic [POS_W-1:0] LEFT_RST     = 20'd0;
    localparam logic [POS_W-1:0] RIGHT_RST    = 20'd163840;  // 640.0
    localparam logic [POS_W-1:0] TOP_RST      = 20'd0;
    localparam logic [POS_W-1:0] BOTTOM_RST   = 20'd122880;  // 480.0

    // Command codes
    typedef enum logic [1:0] {
        CMD_STEP    = 2'd0,
        CMD_PLACE   = 2'd1,
        CMD_IMPULSE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_IMP_LOAD,
        S_DIV,
        S_ACC,
        S_SQX,
        S_SQY,
        S_SQ_SUM,
        S_SQRT,
        S_DEN_MUL,
        S_DEN_SET,
        S_PUSH_MUL,
        S_PUSH_LOAD,
        S_DAMP_MUL,
        S_DAMP_SET,
        S_MOVE,
        S_DONE
    } state_t;

    // Configuration seen by the core
    typedef struct packed {
        logic        [Q16_W-1:0] mass;
        logic        [Q16_W-1:0] push_strength;
        logic        [Q16_W-1:0] damping;
        logic signed [POS_W-1:0] border_left;
        logic signed [POS_W-1:0] border_right;
        logic signed [POS_W-1:0] border_top;
        logic signed [POS_W-1:0] border_bottom;
    } cfg_t;

    // One command item
    typedef struct packed {
        cmd_t                    cmd;
        logic                    held;
        logic                    in_hand;
        logic signed [POS_W-1:0] push_x;
        logic signed [POS_W-1:0] push_y;
        logic signed [POS_W-1:0] place_x;
        logic signed [POS_W-1:0] place_y;
        logic signed [POS_W-1:0] impulse_x;
        logic signed [POS_W-1:0] impulse_y;
    } item_t;

    // One result item
    typedef struct packed {
        logic signed [POS_W-1:0] vel_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } res_t;

endpackage

@@ hw/rtl/dpms_sub.sv @@
// Shared unsigned subtract/compare unit of the puck motion sequencer.
// Serves both the square root and the division steps; uses dpms_pkg.

module dpms_sub (
    input  logic [dpms_pkg::SUB_W-1:0] a,
    input  logic [dpms_pkg::SUB_W-1:0] b,
    output logic [dpms_pkg::SUB_W-1:0] diff,
    output logic                       ge
);

    logic [dpms_pkg::SUB_W:0] wide;

    // One extra bit carries the borrow
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[dpms_pkg::SUB_W-1:0];
    assign ge   = ~wide[dpms_pkg::SUB_W];

endmodule

@@ hw/rtl/dpms_cfg.sv @@
// APB-style configuration registers of the puck motion block.
// Uses dpms_pkg for the register map, reset values and the cfg_t struct.

module dpms_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpms_pkg::ADDR_W-1:0] paddr,
    input  logic [dpms_pkg::DATA_W-1:0] pwdata,
    output logic [dpms_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output dpms_pkg::cfg_t              cfg
);

    dpms_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[dpms_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mass          <= dpms_pkg::MASS_RST;
            cfg_reg.push_strength <= dpms_pkg::PUSH_RST;
            cfg_reg.damping       <= dpms_pkg::DAMP_RST;
            cfg_reg.border_left   <= dpms_pkg::LEFT_RST;
            cfg_reg.border_right  <= dpms_pkg::RIGHT_RST;
            cfg_reg.border_top    <= dpms_pkg::TOP_RST;
            cfg_reg.border_bottom <= dpms_pkg::BOTTOM_RST;
        end else if (wr_en) begin
            case (idx)
                dpms_pkg::REG_MASS:
                    cfg_reg.mass <= pwdata[dpms_pkg::Q16_W-1:0];
                dpms_pkg::REG_PUSH_STRENGTH:
                    cfg_reg.push_strength <= pwdata[dpms_pkg::Q16_W-1:0];
                dpms_pkg::REG_DAMPING:
                    cfg_reg.damping <= pwdata[dpms_pkg::Q16_W-1:0];
                dpms_pkg::REG_BORDER_LEFT:
                    cfg_reg.border_left <= pwdata[dpms_pkg::POS_W-1:0];
                dpms_pkg::REG_BORDER_RIGHT:
                    cfg_reg.border_right <= pwdata[dpms_pkg::POS_W-1:0];
                dpms_pkg::REG_BORDER_TOP:
                    cfg_reg.border_top <= pwdata[dpms_pkg::POS_W-1:0];
                dpms_pkg::REG_BORDER_BOTTOM:
                    cfg_reg.border_bottom <= pwdata[dpms_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux; borders come back sign-extended
    always_comb begin
        case (idx)
            dpms_pkg::REG_MASS:
                prdata = 32'(cfg_reg.mass);
            dpms_pkg::REG_PUSH_STRENGTH:
                prdata = 32'(cfg_reg.push_strength);
            dpms_pkg::REG_DAMPING:
                prdata = 32'(cfg_reg.damping);
            dpms_pkg::REG_BORDER_LEFT:
                prdata = 32'(cfg_reg.border_left);
            dpms_pkg::REG_BORDER_RIGHT:
                prdata = 32'(cfg_reg.border_right);
            dpms_pkg::REG_BORDER_TOP:
                prdata = 32'(cfg_reg.border_top);
            dpms_pkg::REG_BORDER_BOTTOM:
                prdata = 32'(cfg_reg.border_bottom);
            default:
                prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/dpms_core.sv @@
// Sequencer and state of the puck motion block: one shared multiplier and
// one shared subtract unit (dpms_sub) run the square root, divisions and
// damping, while the move adds and clamps on its own. Uses dpms_pkg.

module dpms_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  dpms_pkg::cfg_t  cfg,
    input  logic            start,
    input  dpms_pkg::item_t item,
    output logic            ready,
    input  logic            out_free,
    output logic            res_valid,
    output dpms_pkg::res_t  res
);

    localparam int PW = dpms_pkg::POS_W;

    dpms_pkg::state_t state_reg, state_next;
    dpms_pkg::item_t  item_reg, item_next;
    logic                             ax_reg, ax_next;
    logic [dpms_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [PW-1:0]             pos_reg [2];
    logic signed [PW-1:0]             pos_next [2];
    logic signed [PW-1:0]             vel_reg [2];
    logic signed [PW-1:0]             vel_next [2];
    logic [dpms_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [dpms_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [dpms_pkg::NQ_W-1:0]        nq_reg, nq_next;
    logic [dpms_pkg::ROOT_W-1:0]      root_reg, root_next;
    logic [dpms_pkg::RAD_W-1:0]       rad_reg, rad_next;
    logic [dpms_pkg::SQ_W-1:0]        sq_reg, sq_next;
    logic [dpms_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic                             neg_reg, neg_next;

    // Shared units
    logic [dpms_pkg::MUL_A_W-1:0] mul_a;
    logic [dpms_pkg::MUL_B_W-1:0] mul_b;
    logic [dpms_pkg::SUB_W-1:0]   sub_a, sub_b, sub_diff;
    logic                         sub_ge;

    // Per-axis selections
    logic signed [PW-1:0] push_ax, imp_ax, lo_ax, hi_ax, vel_ax, pos_ax;
    logic [PW-1:0]        push_mag, imp_mag, vel_mag;
    logic [dpms_pkg::Q16_W-1:0] mass_div;
    logic signed [29:0]   qs, vsum;
    logic signed [PW:0]   psum, pclamp;
    logic                 clamped;
    logic [PW-1:0]        damped;

    function automatic logic [PW-1:0] mag20(input logic signed [PW-1:0] v);
        mag20 = v[PW-1] ? PW'(-v) : PW'(v);
    endfunction

    function automatic logic signed [PW-1:0] sat20(input logic signed [29:0] v);
        logic signed [29:0] vmax;
        logic signed [29:0] vmin;
        vmax = 30'sd524287;
        vmin = -30'sd524288;
        if (v > vmax) begin
            sat20 = PW'(vmax);
        end else if (v < vmin) begin
            sat20 = PW'(vmin);
        end else begin
            sat20 = v[PW-1:0];
        end
    endfunction

    dpms_sub u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    assign mass_div = (cfg.mass == '0) ? dpms_pkg::Q16_W'(1) : cfg.mass;
    assign push_ax  = ax_reg ? item_reg.push_y : item_reg.push_x;
    assign imp_ax   = ax_reg ? item_reg.impulse_y : item_reg.impulse_x;
    assign lo_ax    = ax_reg ? cfg.border_top : cfg.border_left;
    assign hi_ax    = ax_reg ? cfg.border_bottom : cfg.border_right;
    assign vel_ax   = vel_reg[ax_reg];
    assign pos_ax   = pos_reg[ax_reg];
    assign push_mag = mag20(push_ax);
    assign imp_mag  = mag20(imp_ax);
    assign vel_mag  = mag20(vel_ax);

    assign ready     = (state_reg == dpms_pkg::S_IDLE);
    assign res_valid = (state_reg == dpms_pkg::S_DONE) && out_free;
    assign res.pos_x = pos_reg[0];
    assign res.pos_y = pos_reg[1];
    assign res.vel_x = vel_reg[0];
    assign res.vel_y = vel_reg[1];

    // Velocity plus signed quotient, position plus velocity with clamp
    always_comb begin
        qs   = 30'(nq_reg);
        if (neg_reg) begin
            qs = -qs;
        end
        vsum = 30'(vel_ax) + qs;

        psum    = (PW+1)'(pos_ax) + (PW+1)'(vel_ax);
        pclamp  = psum;
        clamped = 1'b0;
        if (pclamp < (PW+1)'(lo_ax)) begin
            pclamp  = (PW+1)'(lo_ax);
            clamped = 1'b1;
        end
        if (pclamp > (PW+1)'(hi_ax)) begin
            pclamp  = (PW+1)'(hi_ax);
            clamped = 1'b1;
        end
        damped = prod_reg[35:16];
    end

    // State register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpms_pkg::S_IDLE;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            vel_reg[0] <= '0;
            vel_reg[1] <= '0;
            ax_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            ax_reg    <= ax_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        nq_reg   <= nq_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        sq_reg   <= sq_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    // Sequencer: next state and datapath control
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        ax_next    = ax_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        nq_next    = nq_reg;
        root_next  = root_reg;
        rad_next   = rad_reg;
        sq_next    = sq_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        mul_a      = '0;
        mul_b      = '0;
        sub_a      = '0;
        sub_b      = '0;

        case (state_reg)
            dpms_pkg::S_IDLE: begin
                ax_next = 1'b0;
                if (start) begin
                    item_next = item;
                    case (item.cmd)
                        dpms_pkg::CMD_PLACE: begin
                            pos_next[0] = item.place_x;
                            pos_next[1] = item.place_y;
                            vel_next[0] = '0;
                            vel_next[1] = '0;
                            state_next  = dpms_pkg::S_DONE;
                        end
                        dpms_pkg::CMD_IMPULSE: begin
                            state_next = dpms_pkg::S_IMP_LOAD;
                        end
                        dpms_pkg::CMD_STEP: begin
                            if (item.held) begin
                                state_next = dpms_pkg::S_DONE;
                            end else if (item.in_hand &&
                                         (item.push_x != '0 || item.push_y != '0)) begin
                                state_next = dpms_pkg::S_SQX;
                            end else begin
                                state_next = dpms_pkg::S_DAMP_MUL;
                            end
                        end
                        default: begin
                            state_next = dpms_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Impulse divide: |imp| << 8 over mass
            dpms_pkg::S_IMP_LOAD: begin
                rem_next   = '0;
                nq_next    = {imp_mag, 8'b0};
                den_next   = dpms_pkg::DEN_W'(mass_div);
                neg_next   = imp_ax[PW-1];
                cnt_next   = dpms_pkg::IMP_ITER;
                state_next = dpms_pkg::S_DIV;
            end

            // One restoring division step per cycle
            dpms_pkg::S_DIV: begin
                sub_a    = {rem_reg, nq_reg[dpms_pkg::NQ_W-1]};
                sub_b    = dpms_pkg::SUB_W'(den_reg);
                rem_next = sub_ge ? sub_diff[dpms_pkg::DEN_W-1:0]
                                  : sub_a[dpms_pkg::DEN_W-1:0];
                nq_next  = {nq_reg[dpms_pkg::NQ_W-2:0], sub_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == dpms_pkg::CNT_W'(1)) begin
                    state_next = dpms_pkg::S_ACC;
                end
            end

            // Saturating velocity update, then next axis or next phase
            dpms_pkg::S_ACC: begin
                vel_next[ax_reg] = sat20(vsum);
                if (!ax_reg) begin
                    ax_next = 1'b1;
                    if (item_reg.cmd == dpms_pkg::CMD_IMPULSE) begin
                        state_next = dpms_pkg::S_IMP_LOAD;
                    end else begin
                        state_next = dpms_pkg::S_PUSH_MUL;
                    end
                end else begin
                    ax_next = 1'b0;
                    if (item_reg.cmd == dpms_pkg::CMD_IMPULSE) begin
                        state_next = dpms_pkg::S_DONE;
                    end else begin
                        state_next = dpms_pkg::S_DAMP_MUL;
                    end
                end
            end

            // Squared push length
            dpms_pkg::S_SQX: begin
                mul_a      = dpms_pkg::MUL_A_W'(mag20(item_reg.push_x));
                mul_b      = mag20(item_reg.push_x);
                prod_next  = mul_a * mul_b;
                state_next = dpms_pkg::S_SQY;
            end

            dpms_pkg::S_SQY: begin
                sq_next    = prod_reg[dpms_pkg::SQ_W-1:0];
                mul_a      = dpms_pkg::MUL_A_W'(mag20(item_reg.push_y));
                mul_b      = mag20(item_reg.push_y);
                prod_next  = mul_a * mul_b;
                state_next = dpms_pkg::S_SQ_SUM;
            end

            dpms_pkg::S_SQ_SUM: begin
                rad_next   = {sq_reg + prod_reg[dpms_pkg::SQ_W-1:0], 16'b0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = dpms_pkg::SQRT_ITER;
                state_next = dpms_pkg::S_SQRT;
            end

            // Digit-by-digit square root, two radicand bits per cycle
            dpms_pkg::S_SQRT: begin
                sub_a = dpms_pkg::SUB_W'({rem_reg[dpms_pkg::SQREM_W-1:0],
                                          rad_reg[dpms_pkg::RAD_W-1 -: 2]});
                sub_b = dpms_pkg::SUB_W'({root_reg, 2'b01});
                if (sub_ge) begin
                    rem_next  = dpms_pkg::DEN_W'(sub_diff[dpms_pkg::SQREM_W-1:0]);
                    root_next = {root_reg[dpms_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = dpms_pkg::DEN_W'(sub_a[dpms_pkg::SQREM_W-1:0]);
                    root_next = {root_reg[dpms_pkg::ROOT_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[dpms_pkg::RAD_W-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == dpms_pkg::CNT_W'(1)) begin
                    state_next = dpms_pkg::S_DEN_MUL;
                end
            end

            // Divisor: length * mass
            dpms_pkg::S_DEN_MUL: begin
                mul_a      = root_reg;
                mul_b      = dpms_pkg::MUL_B_W'(mass_div);
                prod_next  = mul_a * mul_b;
                state_next = dpms_pkg::S_DEN_SET;
            end

            dpms_pkg::S_DEN_SET: begin
                den_next   = prod_reg[dpms_pkg::DEN_W-1:0];
                ax_next    = 1'b0;
                state_next = dpms_pkg::S_PUSH_MUL;
            end

            // Dividend: |push| * strength << 16
            dpms_pkg::S_PUSH_MUL: begin
                mul_a      = dpms_pkg::MUL_A_W'(push_mag);
                mul_b      = dpms_pkg::MUL_B_W'(cfg.push_strength);
                prod_next  = mul_a * mul_b;
                state_next = dpms_pkg::S_PUSH_LOAD;
            end

            // Quotient stays below 2^24, so the top dividend bits start
            // as the partial remainder and 25 steps remain
            dpms_pkg::S_PUSH_LOAD: begin
                rem_next   = dpms_pkg::DEN_W'(prod_reg[35:9]);
                nq_next    = {prod_reg[8:0], 16'b0, 3'b000};
                neg_next   = push_ax[PW-1];
                cnt_next   = dpms_pkg::PUSH_ITER;
                state_next = dpms_pkg::S_DIV;
            end

            // Damping: |v| * damping >> 16, sign restored
            dpms_pkg::S_DAMP_MUL: begin
                mul_a      = dpms_pkg::MUL_A_W'(vel_mag);
                mul_b      = dpms_pkg::MUL_B_W'(cfg.damping);
                prod_next  = mul_a * mul_b;
                state_next = dpms_pkg::S_DAMP_SET;
            end

            dpms_pkg::S_DAMP_SET: begin
                vel_next[ax_reg] = vel_ax[PW-1] ? -$signed(damped) : $signed(damped);
                state_next       = dpms_pkg::S_MOVE;
            end

            // Move and clamp to the borders
            dpms_pkg::S_MOVE: begin
                pos_next[ax_reg] = pclamp[PW-1:0];
                if (clamped) begin
                    vel_next[ax_reg] = '0;
                end
                if (!ax_reg) begin
                    ax_next    = 1'b1;
                    state_next = dpms_pkg::S_DAMP_MUL;
                end else begin
                    ax_next    = 1'b0;
                    state_next = dpms_pkg::S_DONE;
                end
            end

            dpms_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = dpms_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = dpms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/damped_puck_motion_step.sv @@
// Damped puck motion step: keeps a 2D position and velocity (signed Q11.8)
// and answers every command transaction with the new state. One command is
// worked at a time, and s_tready stays low until its result is in the output
// register. The shared subtract unit works one division or square root bit per
// cycle: place, hold and the unused command do not use it, a plain step only
// damps and moves, an impulse runs two divisions, and a step with a hand push
// runs the square root and two divisions. Uses dpms_pkg, dpms_cfg, dpms_core.

module damped_puck_motion_step (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Command stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // held[0], in_hand[1], push_x[21:2], push_y[41:22], place_x[61:42],
    // place_y[81:62], impulse_x[101:82], impulse_y[121:102], zero[127:122]
    input  logic [127:0]                s_tdata,
    // cmd[1:0]
    input  logic [1:0]                  s_tuser,

    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pos_x[19:0], pos_y[39:20], vel_x[59:40], vel_y[79:60]
    output logic [79:0]                 m_tdata,

    // Configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpms_pkg::ADDR_W-1:0] paddr,
    input  logic [dpms_pkg::DATA_W-1:0] pwdata,
    output logic [dpms_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    dpms_pkg::cfg_t  cfg;
    dpms_pkg::item_t item;
    dpms_pkg::res_t  res;
    logic            core_ready;
    logic            res_valid;
    logic            out_free;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [79:0]     m_tdata_reg, m_tdata_next;

    // Unpack the command transaction
    assign item.cmd       = dpms_pkg::cmd_t'(s_tuser);
    assign item.held      = s_tdata[0];
    assign item.in_hand   = s_tdata[1];
    assign item.push_x    = s_tdata[21:2];
    assign item.push_y    = s_tdata[41:22];
    assign item.place_x   = s_tdata[61:42];
    assign item.place_y   = s_tdata[81:62];
    assign item.impulse_x = s_tdata[101:82];
    assign item.impulse_y = s_tdata[121:102];

    assign s_tready = core_ready;
    assign out_free = ~m_tvalid_reg | m_tready;

    dpms_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpms_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .start     (s_tvalid & core_ready),
        .item      (item),
        .ready     (core_ready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for damped_puck_motion_step: command stream in, state stream out.
// A scoreboard class predicts every result from its own copy of state and registers.
// Depends on dpms_pkg and the damped_puck_motion_step RTL only.

import dpms_pkg::*;

// Predicts the puck state after each accepted command and checks the result stream
class puck_scoreboard;
    cfg_t                    cfg;
    logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
    res_t                    expected_q[$];
    int unsigned             mismatches;

    function new();
        cfg.mass          = MASS_RST;
        cfg.push_strength = PUSH_RST;
        cfg.damping       = DAMP_RST;
        cfg.border_left   = LEFT_RST;
        cfg.border_right  = RIGHT_RST;
        cfg.border_top    = TOP_RST;
        cfg.border_bottom = BOTTOM_RST;
        pos_x = '0;
        pos_y = '0;
        vel_x = '0;
        vel_y = '0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_MASS:          cfg.mass          = value[Q16_W-1:0];
            REG_PUSH_STRENGTH: cfg.push_strength = value[Q16_W-1:0];
            REG_DAMPING:       cfg.damping       = value[Q16_W-1:0];
            REG_BORDER_LEFT:   cfg.border_left   = value[POS_W-1:0];
            REG_BORDER_RIGHT:  cfg.border_right  = value[POS_W-1:0];
            REG_BORDER_TOP:    cfg.border_top    = value[POS_W-1:0];
            REG_BORDER_BOTTOM: cfg.border_bottom = value[POS_W-1:0];
            default: ;
        endcase
    endfunction

    function longint sat20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Q0.16 multiply of the magnitude, truncated toward zero
    function longint damp(longint v);
        longint d;
        d = cfg.damping;
        if (v < 0) return -(((-v) * d) >>> 16);
        return (v * d) >>> 16;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Advance the predicted state by one command and queue the expected result
    function void note_command(item_t it);
        longint px, py, x, y, vx, vy, m, sq, len, den, s, lo, hi;
        longint unsigned rad, root, b;
        res_t exp_r;
        x  = pos_x;
        y  = pos_y;
        vx = vel_x;
        vy = vel_y;
        px = it.push_x;
        py = it.push_y;
        // zero mass divides like mass one
        m  = (cfg.mass == 0) ? 1 : longint'(cfg.mass);
        if (it.cmd == CMD_PLACE) begin
            x  = it.place_x;
            y  = it.place_y;
            vx = 0;
            vy = 0;
        end else if (it.cmd == CMD_IMPULSE) begin
            vx = sat20(vx + (longint'(it.impulse_x) * 256) / m);
            vy = sat20(vy + (longint'(it.impulse_y) * 256) / m);
        end else if (it.cmd == CMD_STEP && !it.held) begin
            sq = px * px + py * py;
            if (it.in_hand && sq != 0) begin
                // bitwise integer square root of the squared length in Q.16
                rad  = sq << 16;
                root = 0;
                b    = 64'h4000_0000_0000_0000;
                while (b > rad) b >>= 2;
                while (b != 0) begin
                    if (rad >= root + b) begin
                        rad  = rad - (root + b);
                        root = (root >> 1) + b;
                    end else begin
                        root = root >> 1;
                    end
                    b >>= 2;
                end
                len = longint'(root);
                den = len * m;
                s   = longint'(cfg.push_strength) * 65536;
                vx  = sat20(vx + (px * s) / den);
                vy  = sat20(vy + (py * s) / den);
            end
            vx = damp(vx);
            vy = damp(vy);
            x  = x + vx;
            y  = y + vy;
            // low border first, so inverted borders end on the high one
            lo = cfg.border_left;
            hi = cfg.border_right;
            if (x < lo) begin x = lo; vx = 0; end
            if (x > hi) begin x = hi; vx = 0; end
            lo = cfg.border_top;
            hi = cfg.border_bottom;
            if (y < lo) begin y = lo; vy = 0; end
            if (y > hi) begin y = hi; vy = 0; end
        end
        pos_x = x[POS_W-1:0];
        pos_y = y[POS_W-1:0];
        vel_x = vx[POS_W-1:0];
        vel_y = vy[POS_W-1:0];
        exp_r.pos_x = pos_x;
        exp_r.pos_y = pos_y;
        exp_r.vel_x = vel_x;
        exp_r.vel_y = vel_y;
        expected_q.push_back(exp_r);
    endfunction

    // Compare one accepted result against the oldest expectation
    task check_state(res_t got);
        res_t  exp_r;
        string names [4];
        names = '{"pos_x", "pos_y", "vel_x", "vel_y"};
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        exp_r = expected_q.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (got[i*POS_W +: POS_W] !== exp_r[i*POS_W +: POS_W])
                report($sformatf("%s got %0d expected %0d", names[i],
                                 $signed(got[i*POS_W +: POS_W]),
                                 $signed(exp_r[i*POS_W +: POS_W])));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 190;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {
        SET_RESET_VALUES,
        SET_WIDE_OPEN,
        SET_DEGENERATE,
        SET_HEAVY,
        SET_RANDOM
    } setting_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [127:0]         s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    puck_scoreboard sb;
    item_t          cur_item;
    bit             calm;

    damped_puck_motion_step uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Small signed values mostly, full 20-bit range and extremes sometimes
    function automatic int rand_field(int span);
        int r;
        r = $urandom_range(99);
        if (r < 50) return int'($urandom_range(2 * span)) - span;
        if (r < 80) return int'($urandom() & 32'hF_FFFF);
        if (r < 90) return 0;
        return ($urandom_range(1) != 0) ? 524287 : -524288;
    endfunction

    function automatic item_t random_command();
        item_t it;
        int    r;
        r = $urandom_range(99);
        it.cmd = (r < 62) ? CMD_STEP : (r < 74) ? CMD_PLACE :
                 (r < 94) ? CMD_IMPULSE : CMD_NONE;
        it.held    = ($urandom_range(6) == 0);
        it.in_hand = 1'($urandom_range(1));
        it.push_x  = POS_W'(rand_field(4096));
        it.push_y  = POS_W'(rand_field(4096));
        it.place_x = ($urandom_range(1) != 0) ? POS_W'($urandom_range(160000))
                                              : POS_W'(rand_field(200000));
        it.place_y = ($urandom_range(1) != 0) ? POS_W'($urandom_range(120000))
                                              : POS_W'(rand_field(200000));
        it.impulse_x = POS_W'(rand_field(20000));
        it.impulse_y = POS_W'(rand_field(20000));
        return it;
    endfunction

    // Directed command: a and b go to the field pair that the command uses
    function automatic item_t directed_command(cmd_t c, bit hold, bit hand, int a, int b);
        item_t it;
        it = random_command();
        it.cmd     = c;
        it.held    = hold;
        it.in_hand = hand;
        case (c)
            CMD_STEP:    begin it.push_x = POS_W'(a);    it.push_y = POS_W'(b);    end
            CMD_PLACE:   begin it.place_x = POS_W'(a);   it.place_y = POS_W'(b);   end
            CMD_IMPULSE: begin it.impulse_x = POS_W'(a); it.impulse_y = POS_W'(b); end
            default: ;
        endcase
        return it;
    endfunction

    // One command transaction; called and returns at a falling edge
    task automatic send_item(item_t it);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_item = it;
        s_tdata  = {6'b0, it.impulse_y, it.impulse_x, it.place_y, it.place_x,
                    it.push_y, it.push_x, it.in_hand, it.held};
        s_tuser  = it.cmd;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop sending until every expected result has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, longint value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value[DATA_W-1:0];
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, pwdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain, then write all seven registers
    task automatic program_settings(setting_t kind);
        longint vals [7];
        longint lo, hi, t;
        drain();
        vals[REG_MASS]          = MASS_RST;
        vals[REG_PUSH_STRENGTH] = PUSH_RST;
        vals[REG_DAMPING]       = DAMP_RST;
        vals[REG_BORDER_LEFT]   = LEFT_RST;
        vals[REG_BORDER_RIGHT]  = RIGHT_RST;
        vals[REG_BORDER_TOP]    = TOP_RST;
        vals[REG_BORDER_BOTTOM] = BOTTOM_RST;
        case (kind)
            SET_WIDE_OPEN: begin
                vals[REG_MASS]          = 1;
                vals[REG_PUSH_STRENGTH] = 65535;
                vals[REG_DAMPING]       = 65535;
                vals[REG_BORDER_LEFT]   = -524288;
                vals[REG_BORDER_RIGHT]  = 524287;
                vals[REG_BORDER_TOP]    = -524288;
                vals[REG_BORDER_BOTTOM] = 524287;
            end
            // zero mass, no push, full damping, both axes with inverted borders
            SET_DEGENERATE: begin
                vals[REG_MASS]          = 0;
                vals[REG_PUSH_STRENGTH] = 0;
                vals[REG_DAMPING]       = 0;
                vals[REG_BORDER_LEFT]   = 1000;
                vals[REG_BORDER_RIGHT]  = -1000;
                vals[REG_BORDER_TOP]    = 524287;
                vals[REG_BORDER_BOTTOM] = -524288;
            end
            SET_HEAVY: begin
                vals[REG_MASS]          = 65535;
                vals[REG_PUSH_STRENGTH] = 65535;
                vals[REG_DAMPING]       = 32768;
            end
            SET_RANDOM: begin
                vals[REG_MASS] = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                          : $urandom_range(128, 8192);
                vals[REG_PUSH_STRENGTH] = ($urandom_range(1) != 0) ? $urandom_range(65535)
                                                                   : $urandom_range(4096);
                vals[REG_DAMPING] = ($urandom_range(1) != 0) ? $urandom_range(45000, 65535)
                                                             : $urandom_range(65535);
                for (int k = 0; k < 2; k++) begin
                    lo = -longint'($urandom_range(200000));
                    hi = lo + $urandom_range(1000, 300000);
                    if ($urandom_range(4) == 0) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    vals[REG_BORDER_LEFT + 2 * k]  = lo;
                    vals[REG_BORDER_RIGHT + 2 * k] = hi;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 7; k++) apb_write(3'(k), vals[k]);
        @(negedge aclk);
    endtask

    // Result consumer with random stalls
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (!calm && $urandom_range(99) < 25) stall = pick_gap();
            end
        end
    end

    // Transaction monitor: results are checked before the new command is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_state(res_t'(m_tdata));
            if (s_tvalid && s_tready) sb.note_command(cur_item);
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        setting_t phases [9];
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_STEP;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        cur_item = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed, reset register values: every command, hold, zero push, not in hand
        send_item(directed_command(CMD_STEP, 0, 0, 0, 0));
        send_item(directed_command(CMD_PLACE, 0, 0, 25600, 20480));
        send_item(directed_command(CMD_STEP, 0, 1, 768, 1024));
        send_item(directed_command(CMD_STEP, 1, 1, 768, 1024));
        send_item(directed_command(CMD_NONE, 0, 1, 0, 0));
        send_item(directed_command(CMD_IMPULSE, 1, 0, 524287, 524287));
        send_item(directed_command(CMD_STEP, 0, 0, 0, 0));
        send_item(directed_command(CMD_IMPULSE, 0, 1, -524288, -524288));
        send_item(directed_command(CMD_STEP, 0, 1, 0, 0));
        send_item(directed_command(CMD_STEP, 0, 0, 5000, -3000));
        // place outside the borders is taken as given, the next step clamps
        send_item(directed_command(CMD_PLACE, 0, 0, -524288, 524287));
        send_item(directed_command(CMD_STEP, 0, 0, 0, 0));

        // Mass one and open borders: saturated velocity, position clamped at the range ends
        program_settings(SET_WIDE_OPEN);
        send_item(directed_command(CMD_PLACE, 0, 0, 524287, -524288));
        send_item(directed_command(CMD_IMPULSE, 0, 0, 524287, -524288));
        send_item(directed_command(CMD_STEP, 0, 0, 0, 0));
        send_item(directed_command(CMD_STEP, 0, 1, 524287, -524288));
        send_item(directed_command(CMD_IMPULSE, 0, 0, -524288, 524287));

        // Zero mass, zero strength and damping, inverted borders
        program_settings(SET_DEGENERATE);
        send_item(directed_command(CMD_IMPULSE, 0, 0, 1000, -1000));
        send_item(directed_command(CMD_STEP, 0, 1, 1, 1));
        send_item(directed_command(CMD_STEP, 0, 0, 0, 0));

        program_settings(SET_HEAVY);
        send_item(directed_command(CMD_IMPULSE, 0, 0, 524287, 524287));
        send_item(directed_command(CMD_STEP, 0, 1, -524288, 524287));
        send_item(directed_command(CMD_PLACE, 0, 0, 0, 0));

        // Random phases, each under its own register setting
        phases = '{SET_RESET_VALUES, SET_RANDOM, SET_RANDOM, SET_WIDE_OPEN, SET_RANDOM,
                   SET_HEAVY, SET_RANDOM, SET_DEGENERATE, SET_RANDOM};
        foreach (phases[p]) begin
            program_settings(phases[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 64 == 0) calm = ($urandom_range(4) == 0);
                // occasional hold-off until the block is empty
                if ($urandom_range(149) == 0) drain();
                send_item(random_command());
            end
        end

        // Wait out the last results, then watch for strays
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ damped_puck_motion_step.f @@
hw/rtl/dpms_pkg.sv
hw/rtl/dpms_sub.sv
hw/rtl/dpms_cfg.sv
hw/rtl/dpms_core.sv
hw/rtl/damped_puck_motion_step.sv
tb/testbench.sv
